### sv/atm_pkg.sv
// Shared types, codes and pulse constants for the attitude thruster mixer.
`default_nettype none

package atm_pkg;

  localparam int MIX_W = 22;            // width of a mixed thrust sum, 1/(1024*45) units
  localparam int PULSE_W = 11;

  localparam int PULSE_MIN = 1350;
  localparam int PULSE_MAX = 1650;
  localparam int PULSE_MID = 1500;
  localparam int DEAD_LO = 1450;
  localparam int DEAD_HI = 1550;
  localparam int HALF_TURN = 11520;
  localparam int FULL_TURN = 23040;
  localparam int PULSE_SCALE = 1536;    // 1024*45*5 / 150; one pulse step = 1536 / 5 units
  localparam int DIV3_RECIP = 43691;    // ceil(2^17 / 3)
  localparam int DIV3_SHIFT = 17;

  typedef enum logic [1:0] {
    KIND_IMU  = 2'd0,
    KIND_STEP = 2'd1,
    KIND_CMD  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CMD_FORWARD  = 3'd0,
    CMD_BACKWARD = 3'd1,
    CMD_UP       = 3'd2,
    CMD_DOWN     = 3'd3,
    CMD_STOP     = 3'd4,
    CMD_DEPTH    = 3'd5,
    CMD_RSVD6    = 3'd6,
    CMD_RSVD7    = 3'd7
  } cmd_t;

  typedef enum logic {
    REG_POWER   = 1'b0,
    REG_HEADING = 1'b1
  } reg_idx_t;

  function automatic logic [PULSE_W-1:0] deadband(input logic [PULSE_W-1:0] v);
    logic [PULSE_W-1:0] r;
    r = v;
    if (v > PULSE_W'(DEAD_LO) && v < PULSE_W'(DEAD_HI)) begin
      r = PULSE_W'(PULSE_MID);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/atm_pulse.sv
// Maps one mixed thrust sum to a clamped servo pulse width.
`default_nettype none

module atm_pulse
  import atm_pkg::*;
(
  input  wire logic signed [MIX_W-1:0]   mix,
  output logic             [PULSE_W-1:0] pulse
);

  localparam int N_W = 26;
  localparam int X_W = 13;
  localparam int P_W = X_W + 16;

  logic signed [N_W-1:0] n;
  logic        [X_W-1:0] x;
  logic        [P_W-1:0] prod;

  // n = 1500*1536 + 5*mix; pulse = floor(n / 1536) = floor((n >> 9) / 3)
  assign n = N_W'(PULSE_MID * PULSE_SCALE) + N_W'(mix) * N_W'(5);
  assign x = n[X_W+8:9];
  assign prod = P_W'(x) * P_W'(DIV3_RECIP);

  always_comb begin
    if (n < N_W'(PULSE_MIN * PULSE_SCALE)) begin
      pulse = PULSE_W'(PULSE_MIN);
    end else if (n >= N_W'((PULSE_MAX + 1) * PULSE_SCALE)) begin
      pulse = PULSE_W'(PULSE_MAX);
    end else begin
      pulse = prod[DIV3_SHIFT+PULSE_W-1:DIV3_SHIFT];
    end
  end

endmodule

`default_nettype wire

### sv/attitude_thruster_mixer.sv
// Top level: attitude state, command decode, mixer stage and servo output register.
// Takes one beat per clock while in_ready is high. IMU reports and motion commands
// update the attitude and thrust state at the edge that accepts them and give no
// result. A control step gives one result: the accepting edge registers the
// bias-corrected yaw and the four mixed thrust sums in the mixer stage, and when that
// stage advances they are turned into clamped, mirrored and deadbanded pulse widths in
// the output register, where out_valid rises.
// Back-pressure on the output holds both stages; input ready follows the mixer stage.
`default_nettype none

module attitude_thruster_mixer
  import atm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                kind,
  input  wire logic signed [15:0]        pitch_sample,
  input  wire logic signed [15:0]        roll_sample,
  input  wire logic signed [15:0]        yaw_sample,
  input  wire logic [2:0]                command,
  input  wire logic signed [11:0]        depth_value,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [PULSE_W-1:0]        servo_left,
  output logic      [PULSE_W-1:0]        servo_right,
  output logic      [PULSE_W-1:0]        servo_left_up,
  output logic      [PULSE_W-1:0]        servo_right_up,
  output logic signed [16:0]             yaw_corrected
);

  localparam int E_W = 19;

  logic signed [11:0] power_level;
  logic signed [14:0] heading_target;
  logic signed [15:0] pitch_now, roll_now, yaw_now;
  logic signed [15:0] pitch_offset, roll_offset, yaw_offset;
  logic signed [11:0] drive_power;
  logic signed [11:0] dive_thrust;

  logic                    s1_valid;
  logic signed [MIX_W-1:0] mix_left, mix_right, mix_lup, mix_rup;
  logic signed [16:0]      cy_s1;

  logic cfg_write;
  logic accept;
  logic s1_advance;
  logic bias_empty;

  logic signed [16:0]      cp, cr, cy;
  logic signed [E_W-1:0]   e_raw, e_wrap;
  logic signed [MIX_W-1:0] pw45, dv45;
  logic signed [MIX_W-1:0] mix_left_next, mix_right_next, mix_lup_next, mix_rup_next;
  logic [PULSE_W-1:0]      p_left, p_right, p_lup, p_rup;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_POWER:   prdata = 32'(power_level);
      REG_HEADING: prdata = 32'(heading_target);
      default:     prdata = '0;
    endcase
  end

  // output register empties or drains -> mixer stage may move on
  assign s1_advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_advance;
  assign accept = in_valid && in_ready;
  assign bias_empty = (pitch_offset == '0) && (roll_offset == '0) && (yaw_offset == '0);

  // mixer stage arithmetic from current state
  assign cp = 17'(pitch_offset) - 17'(pitch_now);
  assign cr = 17'(roll_offset) - 17'(roll_now);
  assign cy = 17'(yaw_offset) - 17'(yaw_now);
  assign e_raw = E_W'(heading_target) - E_W'(cy);

  always_comb begin
    priority if (e_raw > E_W'(HALF_TURN)) begin
      e_wrap = e_raw - E_W'(FULL_TURN);
    end else if (e_raw < -E_W'(HALF_TURN)) begin
      e_wrap = e_raw + E_W'(FULL_TURN);
    end else begin
      e_wrap = e_raw;
    end
  end

  assign pw45 = MIX_W'(drive_power) * MIX_W'(45);
  assign dv45 = MIX_W'(dive_thrust) * MIX_W'(45);
  assign mix_left_next  = pw45 + (MIX_W'(e_wrap) <<< 3);
  assign mix_right_next = pw45 - (MIX_W'(e_wrap) <<< 3);
  assign mix_lup_next   = dv45 + (MIX_W'(cp) <<< 4) - MIX_W'(cr) * MIX_W'(10);
  assign mix_rup_next   = dv45 + (MIX_W'(cp) <<< 4) + MIX_W'(cr) * MIX_W'(10);

  // attitude and thrust state
  always_ff @(posedge clk) begin
    if (rst) begin
      power_level    <= '0;
      heading_target <= '0;
      pitch_now      <= '0;
      roll_now       <= '0;
      yaw_now        <= '0;
      pitch_offset   <= '0;
      roll_offset    <= '0;
      yaw_offset     <= '0;
      drive_power    <= '0;
      dive_thrust    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_POWER: begin
            power_level <= pwdata[11:0];
            drive_power <= pwdata[11:0];
          end
          REG_HEADING: heading_target <= pwdata[14:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (kind_t'(kind))
          KIND_IMU: begin
            if (bias_empty) begin
              pitch_offset <= pitch_sample;
              roll_offset  <= roll_sample;
              yaw_offset   <= yaw_sample;
            end
            pitch_now <= pitch_sample;
            roll_now  <= roll_sample;
            yaw_now   <= yaw_sample;
          end
          KIND_CMD: begin
            unique case (cmd_t'(command))
              CMD_FORWARD: drive_power <= power_level;
              CMD_BACKWARD: begin
                // saturate the one value whose negation overflows
                if (power_level == 12'sh800) begin
                  drive_power <= 12'sh7FF;
                end else begin
                  drive_power <= -power_level;
                end
              end
              CMD_UP:   dive_thrust <= 12'sd512;
              CMD_DOWN: dive_thrust <= -12'sd512;
              CMD_STOP: begin
                drive_power <= '0;
                dive_thrust <= '0;
              end
              CMD_DEPTH: dive_thrust <= depth_value;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  // mixer stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (kind_t'(kind) == KIND_STEP);
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mix_left  <= mix_left_next;
      mix_right <= mix_right_next;
      mix_lup   <= mix_lup_next;
      mix_rup   <= mix_rup_next;
      cy_s1     <= cy;
    end
  end

  atm_pulse u_pulse_left     (.mix(mix_left),  .pulse(p_left));
  atm_pulse u_pulse_right    (.mix(mix_right), .pulse(p_right));
  atm_pulse u_pulse_left_up  (.mix(mix_lup),   .pulse(p_lup));
  atm_pulse u_pulse_right_up (.mix(mix_rup),   .pulse(p_rup));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      servo_left     <= deadband(p_left);
      servo_right    <= deadband(p_right);
      // mirror the left vertical thruster about mid pulse
      servo_left_up  <= deadband(PULSE_W'(2 * PULSE_MID) - p_lup);
      servo_right_up <= deadband(p_rup);
      yaw_corrected  <= cy_s1;
    end
  end

endmodule

`default_nettype wire

### test/attitude_thruster_mixer_test.sv
// Self-checking testbench for the attitude thruster mixer: random and directed beats, servo checks.
`default_nettype none

module attitude_thruster_mixer_test;
  import atm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t              kind;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    cmd_t               command;
    logic signed [11:0] depth;
  } beat_t;

  typedef struct {
    logic [PULSE_W-1:0] left;
    logic [PULSE_W-1:0] right;
    logic [PULSE_W-1:0] left_up;
    logic [PULSE_W-1:0] right_up;
    logic signed [16:0] yaw;
  } servo_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [PULSE_W-1:0] servo_left, servo_right, servo_left_up, servo_right_up;
  logic signed [16:0] yaw_corrected;

  beat_t cur = '{KIND_NONE, '0, '0, '0, CMD_FORWARD, '0};
  beat_t backlog[$];
  servo_t servo_due[$];

  // mirror of the block's attitude and thrust state
  logic signed [11:0] power_reg = '0;
  logic signed [14:0] heading_reg = '0;
  logic signed [15:0] pitch_now = '0, roll_now = '0, yaw_now = '0;
  logic signed [15:0] pitch_off = '0, roll_off = '0, yaw_off = '0;
  logic signed [11:0] drive_power = '0;
  logic signed [11:0] dive_thrust = '0;

  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  int mismatches = 0;
  int imu_beats = 0, step_beats = 0, cmd_beats = 0, idle_beats = 0;
  int servo_checked = 0, config_writes = 0;

  attitude_thruster_mixer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(cur.kind), .pitch_sample(cur.pitch), .roll_sample(cur.roll),
    .yaw_sample(cur.yaw), .command(cur.command), .depth_value(cur.depth),
    .out_valid(out_valid), .out_ready(out_ready),
    .servo_left(servo_left), .servo_right(servo_right),
    .servo_left_up(servo_left_up), .servo_right_up(servo_right_up),
    .yaw_corrected(yaw_corrected)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [PULSE_W-1:0] thrust_to_pulse(input longint m);
    longint n;
    n = longint'(PULSE_MID) * 1536 + 5 * m;
    if (n < longint'(PULSE_MIN) * 1536) return PULSE_W'(PULSE_MIN);
    n = n / 1536;
    if (n > PULSE_MAX) n = PULSE_MAX;
    return PULSE_W'(n);
  endfunction

  function automatic logic [PULSE_W-1:0] snap_mid(input logic [PULSE_W-1:0] v);
    return (v > DEAD_LO && v < DEAD_HI) ? PULSE_W'(PULSE_MID) : v;
  endfunction

  function automatic servo_t mix_servos();
    longint cp, cr, cy, err, pw, dv;
    logic [PULSE_W-1:0] lu;
    servo_t s;
    cp = -(longint'(pitch_now) - longint'(pitch_off));
    cr = -(longint'(roll_now) - longint'(roll_off));
    cy = -(longint'(yaw_now) - longint'(yaw_off));
    err = longint'(heading_reg) - cy;
    // wrap once only
    if (err > HALF_TURN) err -= FULL_TURN;
    else if (err < -HALF_TURN) err += FULL_TURN;
    pw = 45 * longint'(drive_power);
    dv = 45 * longint'(dive_thrust);
    s.left = snap_mid(thrust_to_pulse(pw + 8 * err));
    s.right = snap_mid(thrust_to_pulse(pw - 8 * err));
    lu = PULSE_W'(2 * PULSE_MID) - thrust_to_pulse(dv + 16 * cp - 10 * cr);
    s.left_up = snap_mid(lu);
    s.right_up = snap_mid(thrust_to_pulse(dv + 16 * cp + 10 * cr));
    s.yaw = 17'(cy);
    return s;
  endfunction

  // advance the state mirror by one accepted beat
  task automatic absorb_beat(input beat_t b);
    case (b.kind)
      KIND_IMU: begin
        if (pitch_off == 0 && roll_off == 0 && yaw_off == 0) begin
          pitch_off = b.pitch;
          roll_off = b.roll;
          yaw_off = b.yaw;
        end
        pitch_now = b.pitch;
        roll_now = b.roll;
        yaw_now = b.yaw;
        imu_beats++;
      end
      KIND_CMD: begin
        case (b.command)
          CMD_FORWARD: drive_power = power_reg;
          CMD_BACKWARD: drive_power = (power_reg == -12'sd2048) ? 12'sd2047 : 12'(-int'(power_reg));
          CMD_UP: dive_thrust = 12'sd512;
          CMD_DOWN: dive_thrust = -12'sd512;
          CMD_STOP: begin
            drive_power = '0;
            dive_thrust = '0;
          end
          CMD_DEPTH: dive_thrust = b.depth;
          default: ;
        endcase
        cmd_beats++;
      end
      KIND_STEP: begin
        servo_due.push_back(mix_servos());
        step_beats++;
      end
      default: idle_beats++;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && psel && penable && pwrite && pready) begin
      case (paddr)
        3'(4 * REG_POWER): begin
          power_reg = pwdata[11:0];
          drive_power = pwdata[11:0];
        end
        3'(4 * REG_HEADING): heading_reg = pwdata[14:0];
        default: ;
      endcase
      config_writes++;
    end
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_beat(cur);
      if (!in_valid || in_ready) begin
        if (backlog.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
          cur <= backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    servo_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (servo_due.size() == 0) begin
          flag_mismatch("unexpected servo beat, left", servo_left, 0);
        end else begin
          want = servo_due.pop_front();
          if (servo_left !== want.left) flag_mismatch("servo_left", servo_left, want.left);
          if (servo_right !== want.right) flag_mismatch("servo_right", servo_right, want.right);
          if (servo_left_up !== want.left_up)
            flag_mismatch("servo_left_up", servo_left_up, want.left_up);
          if (servo_right_up !== want.right_up)
            flag_mismatch("servo_right_up", servo_right_up, want.right_up);
          if (yaw_corrected !== want.yaw)
            flag_mismatch("yaw_corrected", int'(yaw_corrected), int'(want.yaw));
          servo_checked++;
        end
      end
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 37);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (!hold_go) @(posedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #3_200_000;
    $display("Timeout with %0d servo beats outstanding", servo_due.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(2 * FULL_TURN)) - FULL_TURN);
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int pick;
    pick = $urandom_range(99);
    b.kind = pick < 30 ? KIND_IMU : pick < 65 ? KIND_STEP : pick < 95 ? KIND_CMD : KIND_NONE;
    b.pitch = rand_angle();
    b.roll = rand_angle();
    b.yaw = rand_angle();
    b.command = cmd_t'($urandom_range(7));
    b.depth = 12'($urandom);
    return b;
  endfunction

  task automatic push_imu(input int p, input int r, input int y);
    beat_t b;
    b = rand_beat();
    b.kind = KIND_IMU;
    b.pitch = 16'(p);
    b.roll = 16'(r);
    b.yaw = 16'(y);
    backlog.push_back(b);
  endtask

  task automatic push_cmd(input cmd_t c, input int d);
    beat_t b;
    b = rand_beat();
    b.kind = KIND_CMD;
    b.command = c;
    b.depth = 12'(d);
    backlog.push_back(b);
  endtask

  task automatic push_kind(input kind_t k);
    beat_t b;
    b = rand_beat();
    b.kind = k;
    backlog.push_back(b);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every beat is in and every servo beat is out, then let the pipe settle
  task automatic drain();
    while (backlog.size() != 0 || in_valid || servo_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input int power, input int heading, input int count);
    drain();
    write_reg(REG_POWER, power);
    write_reg(REG_HEADING, heading);
    repeat (count) backlog.push_back(rand_beat());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // bias capture: an all-zero report leaves the offsets clear, the next one with a
    // zero pitch is captured, and later reports must not overwrite it
    push_kind(KIND_STEP);
    push_imu(0, 0, 0);
    push_imu(0, 0, 640);
    push_imu(1000, -2000, 3000);
    push_kind(KIND_STEP);
    push_cmd(CMD_UP, 0);
    push_kind(KIND_STEP);
    push_cmd(CMD_DOWN, 0);
    push_kind(KIND_STEP);
    push_cmd(CMD_DEPTH, 2047);
    push_kind(KIND_STEP);
    push_cmd(CMD_DEPTH, -2048);
    push_kind(KIND_STEP);
    push_cmd(CMD_FORWARD, 0);
    push_cmd(CMD_BACKWARD, 0);
    push_cmd(CMD_STOP, 0);
    push_cmd(CMD_RSVD6, 1000);
    push_cmd(CMD_RSVD7, -1000);
    push_kind(KIND_NONE);
    push_kind(KIND_STEP);
    push_imu(FULL_TURN, -FULL_TURN, -FULL_TURN);
    push_kind(KIND_STEP);
    push_imu(-FULL_TURN, FULL_TURN, FULL_TURN);
    push_kind(KIND_STEP);
    push_imu(-32768, 32767, -32768);
    push_kind(KIND_STEP);

    run_phase(1024, 0, 250);

    // negating the most negative power saturates
    drain();
    write_reg(REG_POWER, -2048);
    write_reg(REG_HEADING, -HALF_TURN);
    push_cmd(CMD_BACKWARD, 0);
    push_kind(KIND_STEP);
    push_cmd(CMD_FORWARD, 0);
    push_kind(KIND_STEP);
    repeat (250) backlog.push_back(rand_beat());

    drain();
    calm = 1'b1;
    run_phase(2047, 16383, 250);
    drain();
    calm = 1'b0;

    run_phase(-1024, HALF_TURN, 250);
    hold_go = 1'b1;
    run_phase(int'($urandom_range(2048)) - 1024, -16384, 250);
    run_phase(int'($urandom_range(2048)) - 1024,
              int'($urandom_range(2 * HALF_TURN)) - HALF_TURN, 250);
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d IMU reports, %0d control steps, %0d motion commands, %0d unused kinds",
             imu_beats, step_beats, cmd_beats, idle_beats);
    $display("Checked %0d servo beats across %0d register writes", servo_checked, config_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
